// ----- sv/ecpcd_pkg.sv -----
// ----------------------------------------------------------------------------
// ecpcd_pkg: shared types and constants of the pixel change detector
// Gray conversion weights, register codes and reset values, queue sizing and
// the control structs passed between the front, queue and back parts.
// ----------------------------------------------------------------------------
package ecpcd_pkg;

  localparam int GRAY_W     = 8;
  localparam int COORD_W    = 10;
  localparam int DIM_W      = 11;
  localparam int THR_W      = 8;
  localparam int GRAY_SUM_W = 23;
  localparam int GRAY_SHIFT = 14;

  localparam logic [GRAY_SUM_W-1:0] WEIGHT_R   = 23'd4899;
  localparam logic [GRAY_SUM_W-1:0] WEIGHT_G   = 23'd9617;
  localparam logic [GRAY_SUM_W-1:0] WEIGHT_B   = 23'd1868;
  localparam logic [GRAY_SUM_W-1:0] GRAY_ROUND = 23'd8192;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2
  } cfg_reg_t;

  localparam logic [THR_W-1:0] THRESHOLD_RST = 8'd15;
  localparam logic [DIM_W-1:0] WIDTH_RST     = 11'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST    = 11'd480;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic pop;
    logic busy;
  } back_ctl_t;

endpackage

// ----- sv/ecpcd_if.sv -----
// ----------------------------------------------------------------------------
// ecpcd_if: handshake channels of the pixel change detector
// One channel carries RGB pixels in, the other carries change items out.
// ----------------------------------------------------------------------------
interface ecpcd_pixel_if ();
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       suppress;

  modport source (output valid, red, green, blue, suppress, input ready);
  modport sink (input valid, red, green, blue, suppress, output ready);
endinterface

interface ecpcd_event_if ();
  logic       valid;
  logic       ready;
  logic [9:0] event_x;
  logic [9:0] event_y;
  logic       polarity;

  modport source (output valid, event_x, event_y, polarity, input ready);
  modport sink (input valid, event_x, event_y, polarity, output ready);
endinterface

// ----- sv/event_camera_pixel_change_detector.sv -----
// ----------------------------------------------------------------------------
// event_camera_pixel_change_detector: frame-difference change detector
// Streams raster-ordered RGB pixels against a stored gray frame and emits a
// change item for every pixel whose gray level moved past the threshold.
// ----------------------------------------------------------------------------
// Usage:
// Pixels enter on in_pix (valid/ready), one per clock, left to right and top
// to bottom. Each pixel yields zero or one item on out_evt carrying its
// column, row and polarity (0 brighter, 1 darker). Threshold and frame size
// are written over the APB port while the block is idle.
// Throughput is one pixel per cycle while the store stage does not hold, set by
// the single read-modify-write of the frame store per pixel: a read as the pixel
// leaves the queue, then compare and write-back; out_evt.valid is registered.
// A four-entry queue sits between intake and the store access, and a single
// output register sits after the compare. When out_evt.ready is low with an
// item waiting, the store stage holds as soon as it reaches the next pixel
// that raises an item; pixels that raise none keep passing. Intake continues
// until the queue fills and then in_pix.ready drops.
// Reset clears the raster counters and the output state and marks the store
// as holding no frame; the first complete frame after reset, like any
// suppressed pixel, only refreshes the store. The store itself is not
// cleared, so no clearing time is spent after reset.
// ----------------------------------------------------------------------------
module event_camera_pixel_change_detector import ecpcd_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  ecpcd_pixel_if.sink        in_pix,
  ecpcd_event_if.source      out_evt,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int AW  = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int QW  = AW + 2 * COORD_W + GRAY_W + 1;
  localparam int QLW = $clog2(QUEUE_DEPTH + 1);

  logic [THR_W-1:0] thr_r, thr_nxt;
  logic [DIM_W-1:0] width_r, width_nxt;
  logic [DIM_W-1:0] height_r, height_nxt;
  cfg_reg_t         reg_sel;
  logic             wr_en;

  logic               push;
  logic [AW-1:0]      ent_addr;
  logic [COORD_W-1:0] ent_x;
  logic [COORD_W-1:0] ent_y;
  logic [GRAY_W-1:0]  ent_gray;
  logic               ent_check;

  logic [QW-1:0]      q_wdata;
  logic [QW-1:0]      q_rdata;
  q_stat_t            q_stat;
  logic [QLW-1:0]     q_level;

  logic [AW-1:0]      head_addr;
  logic [COORD_W-1:0] head_x;
  logic [COORD_W-1:0] head_y;
  logic [GRAY_W-1:0]  head_gray;
  logic               head_check;

  back_ctl_t          back_ctl;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [GRAY_W-1:0]  ram_rdata;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [GRAY_W-1:0]  ram_wdata;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    thr_nxt    = thr_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    if (wr_en) begin
      case (reg_sel)
        REG_THRESHOLD: thr_nxt    = pwdata[THR_W-1:0];
        REG_WIDTH:     width_nxt  = pwdata[DIM_W-1:0];
        REG_HEIGHT:    height_nxt = pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_THRESHOLD: prdata = PDATA_W'(thr_r);
      REG_WIDTH:     prdata = PDATA_W'(width_r);
      REG_HEIGHT:    prdata = PDATA_W'(height_r);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= THRESHOLD_RST;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else begin
      thr_r    <= thr_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  ecpcd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .pix          (in_pix),
    .frame_width  (width_r),
    .frame_height (height_r),
    .q_full       (q_stat.full),
    .push         (push),
    .ent_addr     (ent_addr),
    .ent_x        (ent_x),
    .ent_y        (ent_y),
    .ent_gray     (ent_gray),
    .ent_check    (ent_check)
  );

  assign q_wdata = {ent_addr, ent_x, ent_y, ent_gray, ent_check};
  assign {head_addr, head_x, head_y, head_gray, head_check} = q_rdata;

  ecpcd_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (q_wdata),
    .pop   (back_ctl.pop),
    .rdata (q_rdata),
    .stat  (q_stat),
    .level (q_level)
  );

  ecpcd_back #(
    .AW (AW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .threshold  (thr_r),
    .q_stat     (q_stat),
    .head_addr  (head_addr),
    .head_x     (head_x),
    .head_y     (head_y),
    .head_gray  (head_gray),
    .head_check (head_check),
    .ctl        (back_ctl),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .evt        (out_evt)
  );

  ecpcd_ram #(
    .WIDTH (GRAY_W),
    .DEPTH (MAX_WIDTH * MAX_HEIGHT)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_evt.valid)
    else $error("output valid not cleared by reset");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    back_ctl.pop |-> q_level != '0)
    else $error("queue popped while empty");

  a_pop_loads_back: assert property (@(posedge clk) disable iff (!rst_n)
    back_ctl.pop |=> back_ctl.busy)
    else $error("popped item did not reach the store stage");

  a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_pix.ready |-> q_level == QLW'(QUEUE_DEPTH))
    else $error("intake stalled with room in the queue");

endmodule

// ----- sv/ecpcd_ram.sv -----
// ----------------------------------------------------------------------------
// ecpcd_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data. A read at the
// address being written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module ecpcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/ecpcd_front.sv -----
// ----------------------------------------------------------------------------
// ecpcd_front: pixel intake and classification
// Converts each accepted pixel to gray, tags it with its raster position and
// frame-store address, and decides whether it may raise a change item.
// ----------------------------------------------------------------------------
module ecpcd_front import ecpcd_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
  input  logic               clk,
  input  logic               rst_n,
  ecpcd_pixel_if.sink        pix,
  input  logic [DIM_W-1:0]   frame_width,
  input  logic [DIM_W-1:0]   frame_height,
  input  logic               q_full,
  output logic               push,
  output logic [AW-1:0]      ent_addr,
  output logic [COORD_W-1:0] ent_x,
  output logic [COORD_W-1:0] ent_y,
  output logic [GRAY_W-1:0]  ent_gray,
  output logic               ent_check
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int CW = ($clog2(MAX_WIDTH + 1) > DIM_W) ? $clog2(MAX_WIDTH + 1) : DIM_W;
  localparam int CH = ($clog2(MAX_HEIGHT + 1) > DIM_W) ? $clog2(MAX_HEIGHT + 1) : DIM_W;

  logic [XW-1:0] col_r, col_nxt;
  logic [YW-1:0] row_r, row_nxt;
  logic          ref_valid_r, ref_valid_nxt;

  logic [CW-1:0]         w_eff;
  logic [CH-1:0]         h_eff;
  logic                  last_col;
  logic                  last_row;
  logic [GRAY_SUM_W-1:0] gray_sum;

  // Out-of-range geometry is clamped to 1..MAX.
  always_comb begin
    if (frame_width == '0) begin
      w_eff = CW'(1);
    end else if (CW'(frame_width) > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(frame_width);
    end
    if (frame_height == '0) begin
      h_eff = CH'(1);
    end else if (CH'(frame_height) > CH'(MAX_HEIGHT)) begin
      h_eff = CH'(MAX_HEIGHT);
    end else begin
      h_eff = CH'(frame_height);
    end
  end

  assign last_col = (CW'(col_r) + CW'(1)) >= w_eff;
  assign last_row = (CH'(row_r) + CH'(1)) >= h_eff;

  assign pix.ready = !q_full;
  assign push      = pix.valid && !q_full;

  assign gray_sum = GRAY_SUM_W'(pix.red) * WEIGHT_R
                  + GRAY_SUM_W'(pix.green) * WEIGHT_G
                  + GRAY_SUM_W'(pix.blue) * WEIGHT_B
                  + GRAY_ROUND;

  assign ent_gray  = gray_sum[GRAY_SHIFT +: GRAY_W];
  assign ent_addr  = AW'(AW'(row_r) * AW'(MAX_WIDTH)) + AW'(col_r);
  assign ent_x     = COORD_W'(col_r);
  assign ent_y     = COORD_W'(row_r);
  assign ent_check = ref_valid_r && !pix.suppress;

  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    ref_valid_nxt = ref_valid_r;
    if (push) begin
      if (last_col) begin
        col_nxt = '0;
        if (last_row) begin
          row_nxt       = '0;
          ref_valid_nxt = 1'b1;
        end else begin
          row_nxt = row_r + YW'(1);
        end
      end else begin
        col_nxt = col_r + XW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      ref_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      ref_valid_r <= ref_valid_nxt;
    end
  end

endmodule

// ----- sv/ecpcd_queue.sv -----
// ----------------------------------------------------------------------------
// ecpcd_queue: short FIFO between the front and back parts
// Holds classified pixels so that intake keeps running while the back part
// waits on the result channel.
// ----------------------------------------------------------------------------
module ecpcd_queue import ecpcd_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PW = $clog2(DEPTH),
  localparam int LW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output q_stat_t          stat,
  output logic [LW-1:0]    level
);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_r, wr_nxt;
  logic [PW-1:0]    rd_r, rd_nxt;
  logic [LW-1:0]    cnt_r, cnt_nxt;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + LW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= wdata;
    end
  end

  assign rdata      = slot_r[rd_r];
  assign stat.full  = (cnt_r == LW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign level      = cnt_r;

endmodule

// ----- sv/ecpcd_back.sv -----
// ----------------------------------------------------------------------------
// ecpcd_back: frame-store update and change decision
// Reads the stored gray level for each queued pixel, compares it with the new
// one, writes the new level back and drives the output register.
// ----------------------------------------------------------------------------
module ecpcd_back import ecpcd_pkg::*; #(
  parameter int AW = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [THR_W-1:0]   threshold,
  input  q_stat_t            q_stat,
  input  logic [AW-1:0]      head_addr,
  input  logic [COORD_W-1:0] head_x,
  input  logic [COORD_W-1:0] head_y,
  input  logic [GRAY_W-1:0]  head_gray,
  input  logic               head_check,
  output back_ctl_t          ctl,
  output logic               ram_re,
  output logic [AW-1:0]      ram_raddr,
  input  logic [GRAY_W-1:0]  ram_rdata,
  output logic               ram_we,
  output logic [AW-1:0]      ram_waddr,
  output logic [GRAY_W-1:0]  ram_wdata,
  ecpcd_event_if.source      evt
);

  logic               b_valid_r, b_valid_nxt;
  logic [AW-1:0]      b_addr_r;
  logic [COORD_W-1:0] b_x_r;
  logic [COORD_W-1:0] b_y_r;
  logic [GRAY_W-1:0]  b_gray_r;
  logic               b_check_r;
  logic               fwd_r;
  logic [GRAY_W-1:0]  fwd_data_r;

  logic               out_valid_r, out_valid_nxt;
  logic [COORD_W-1:0] out_x_r;
  logic [COORD_W-1:0] out_y_r;
  logic               out_pol_r;

  logic [GRAY_W-1:0] prev;
  logic              rise_hit;
  logic              fall_hit;
  logic              hit;
  logic              b_fire;
  logic              pop;

  // The store is written back after it is read, so a read issued in the
  // same cycle as a write to the same entry takes the written value instead.
  assign prev     = fwd_r ? fwd_data_r : ram_rdata;
  assign rise_hit = (b_gray_r > prev) && ((b_gray_r - prev) > threshold);
  assign fall_hit = (prev > b_gray_r) && ((prev - b_gray_r) > threshold);
  assign hit      = b_check_r && (rise_hit || fall_hit);

  assign b_fire = b_valid_r && (!hit || !out_valid_r || evt.ready);
  assign pop    = !q_stat.empty && (!b_valid_r || b_fire);

  assign ctl.pop  = pop;
  assign ctl.busy = b_valid_r;

  assign ram_re    = pop;
  assign ram_raddr = head_addr;
  assign ram_we    = b_fire;
  assign ram_waddr = b_addr_r;
  assign ram_wdata = b_gray_r;

  always_comb begin
    b_valid_nxt = b_valid_r;
    if (pop) begin
      b_valid_nxt = 1'b1;
    end else if (b_fire) begin
      b_valid_nxt = 1'b0;
    end
    out_valid_nxt = (out_valid_r && !evt.ready) || (b_fire && hit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_addr_r   <= head_addr;
      b_x_r      <= head_x;
      b_y_r      <= head_y;
      b_gray_r   <= head_gray;
      b_check_r  <= head_check;
      fwd_r      <= ram_we && (ram_waddr == head_addr);
      fwd_data_r <= ram_wdata;
    end
    if (b_fire && hit) begin
      out_x_r   <= b_x_r;
      out_y_r   <= b_y_r;
      out_pol_r <= !rise_hit;
    end
  end

  assign evt.valid    = out_valid_r;
  assign evt.event_x  = out_x_r;
  assign evt.event_y  = out_y_r;
  assign evt.polarity = out_pol_r;

endmodule

// ----- tb/sv/event_camera_pixel_change_detector_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_camera_pixel_change_detector_test: self-checking bench for the detector
// Streams raster pixels through the block while both channels idle at random.
// A behavioral copy of the gray frame store and the raster counters predicts
// every change item, and each received item is compared in order. Threshold
// and frame size are written over APB between bursts and read back.
// ----------------------------------------------------------------------------
module event_camera_pixel_change_detector_test;
  import ecpcd_pkg::*;

  localparam int MAX_W         = 1024;
  localparam int MAX_H         = 1024;
  localparam int SETTLE_CYCLES = 16;
  localparam int SMALL_ITEMS   = 680;
  localparam int WIDE_ITEMS    = 1100;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       suppress;
  } pixel_t;

  typedef struct packed {
    logic [9:0] x;
    logic [9:0] y;
    logic       pol;
  } change_t;

  typedef enum logic {ROW_CFG, ROW_PIXEL} row_kind_t;
  typedef enum logic [1:0] {CHECK_MODEL, CHECK_NONE, CHECK_EVENT} row_check_t;

  typedef struct packed {
    row_kind_t   kind;
    cfg_reg_t    reg_sel;
    logic [10:0] value;
    pixel_t      pix;
    row_check_t  check;
    change_t     want;
  } plan_row_t;

  localparam pixel_t BLACK   = '{8'd0, 8'd0, 8'd0, 1'b0};
  localparam pixel_t WHITE   = '{8'd255, 8'd255, 8'd255, 1'b0};
  localparam pixel_t RED     = '{8'd255, 8'd0, 8'd0, 1'b0};
  localparam pixel_t GREEN   = '{8'd0, 8'd255, 8'd0, 1'b0};
  localparam pixel_t BLUE    = '{8'd0, 8'd0, 8'd255, 1'b0};
  localparam pixel_t MID     = '{8'd128, 8'd128, 8'd128, 1'b0};
  localparam pixel_t BLACK_S = '{8'd0, 8'd0, 8'd0, 1'b1};
  localparam pixel_t WHITE_S = '{8'd255, 8'd255, 8'd255, 1'b1};
  localparam change_t NO_CHG = '{10'd0, 10'd0, 1'b0};

  // Frame size 2x2 unless a row says otherwise.
  plan_row_t directed_rows [30] = '{
    '{ROW_CFG, REG_WIDTH, 11'd2, BLACK, CHECK_NONE, NO_CHG},
    '{ROW_CFG, REG_HEIGHT, 11'd2, BLACK, CHECK_NONE, NO_CHG},
    '{ROW_CFG, REG_THRESHOLD, 11'd0, BLACK, CHECK_NONE, NO_CHG},
    // The first frame after reset only fills the store.
    '{ROW_PIXEL, REG_THRESHOLD, 11'd0, BLACK, CHECK_NONE, NO_CHG},
    '{ROW_PIXEL, REG_THRESHOLD, 11'd0, WHITE, CHECK_NONE, NO_CHG},
    '{ROW_PIXEL, REG_THRESHOLD, 11'd0, RED, CHECK_NONE, NO_CHG},
    '{ROW_PIXEL, REG_THRESHOLD, 11'd0, BLUE, CHECK_NONE, NO_CHG},
    // With a zero threshold any change fires, no change does not.
    '{ROW_PIXEL, REG_THRESHOLD, 11'd0, BLACK, CHECK_NONE, NO_CHG},
    '{ROW_PIXEL, REG_THRESHOLD, 11'd0, BLACK, CHECK_EVENT, '{10'd1, 10'd0, 1'b1}},
    '{ROW_PIXEL, REG_THRESHOLD, 11'd0, GREEN, CHECK_MODEL, NO_CHG},
    '{ROW_PIXEL, REG_THRESHOLD, 11'd0, WHITE, CHECK_EVENT, '{10'd1, 10'd1, 1'b0}},
    '{ROW_PIXEL, REG_THRESHOLD, 11'd0, WHITE_S, CHECK_NONE, NO_CHG},
    '{ROW_PIXEL, REG_THRESHOLD, 11'd0, WHITE_S, CHECK_NONE, NO_CHG},
    '{ROW_PIXEL, REG_THRESHOLD, 11'd0, BLACK_S, CHECK_NONE, NO_CHG},
    '{ROW_PIXEL, REG_THRESHOLD, 11'd0, BLACK_S, CHECK_NONE, NO_CHG},
    // A full-scale swing never exceeds the top threshold.
    '{ROW_CFG, REG_THRESHOLD, 11'd255, BLACK, CHECK_NONE, NO_CHG},
    '{ROW_PIXEL, REG_THRESHOLD, 11'd0, BLACK, CHECK_NONE, NO_CHG},
    '{ROW_PIXEL, REG_THRESHOLD, 11'd0, BLACK, CHECK_NONE, NO_CHG},
    '{ROW_PIXEL, REG_THRESHOLD, 11'd0, WHITE, CHECK_NONE, NO_CHG},
    '{ROW_PIXEL, REG_THRESHOLD, 11'd0, WHITE, CHECK_NONE, NO_CHG},
    '{ROW_CFG, REG_THRESHOLD, 11'd254, BLACK, CHECK_NONE, NO_CHG},
    '{ROW_PIXEL, REG_THRESHOLD, 11'd0, WHITE, CHECK_EVENT, '{10'd0, 10'd0, 1'b0}},
    '{ROW_PIXEL, REG_THRESHOLD, 11'd0, BLACK, CHECK_NONE, NO_CHG},
    '{ROW_PIXEL, REG_THRESHOLD, 11'd0, BLACK, CHECK_EVENT, '{10'd0, 10'd1, 1'b1}},
    '{ROW_PIXEL, REG_THRESHOLD, 11'd0, WHITE, CHECK_NONE, NO_CHG},
    // Shrinking the width mid-row ends the row on the next pixel.
    '{ROW_CFG, REG_THRESHOLD, 11'd20, BLACK, CHECK_NONE, NO_CHG},
    '{ROW_PIXEL, REG_THRESHOLD, 11'd0, MID, CHECK_MODEL, NO_CHG},
    '{ROW_CFG, REG_WIDTH, 11'd1, BLACK, CHECK_NONE, NO_CHG},
    '{ROW_PIXEL, REG_THRESHOLD, 11'd0, RED, CHECK_MODEL, NO_CHG},
    '{ROW_PIXEL, REG_THRESHOLD, 11'd0, BLUE, CHECK_MODEL, NO_CHG}
  };

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  ecpcd_pixel_if pix_if ();
  ecpcd_event_if evt_if ();

  event_camera_pixel_change_detector #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_pix (pix_if),
    .out_evt(evt_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Mirror of the block: gray frame store, raster position and settings.
  bit [7:0]    gray_store [MAX_W*MAX_H];
  bit          gray_written [MAX_W*MAX_H];
  int unsigned col_cnt = 0;
  int unsigned row_cnt = 0;
  bit          frame_stored = 1'b0;
  int unsigned threshold_q = 15;
  int unsigned width_q = 640;
  int unsigned height_q = 480;

  change_t     pending_changes [$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned errors = 0;
  int unsigned n_pixels = 0;
  int unsigned n_cfg = 0;
  int unsigned n_rise = 0;
  int unsigned n_fall = 0;
  int unsigned n_drains = 0;

  // Gray conversion, saturating compare against the stored pixel, store
  // refresh and raster advance for one accepted pixel.
  function automatic bit predict_pixel(input pixel_t p, output change_t chg);
    int unsigned wd;
    int unsigned ht;
    int unsigned addr;
    int unsigned cur;
    int unsigned prv;
    int unsigned up;
    int unsigned down;
    bit          hit;
    wd = (width_q == 0) ? 1 : ((width_q > MAX_W) ? MAX_W : width_q);
    ht = (height_q == 0) ? 1 : ((height_q > MAX_H) ? MAX_H : height_q);
    addr = row_cnt * MAX_W + col_cnt;
    cur = (int'(p.red) * 4899 + int'(p.green) * 9617 + int'(p.blue) * 1868 + 8192) >> 14;
    prv = gray_store[addr];
    up = (cur > prv) ? cur - prv : 0;
    down = (prv > cur) ? prv - cur : 0;
    hit = frame_stored && !p.suppress && (up > threshold_q || down > threshold_q);
    chg.x = col_cnt[9:0];
    chg.y = row_cnt[9:0];
    chg.pol = (up > threshold_q) ? 1'b0 : 1'b1;
    gray_store[addr] = cur[7:0];
    gray_written[addr] = 1'b1;
    if (col_cnt + 1 >= wd) begin
      col_cnt = 0;
      if (row_cnt + 1 >= ht) begin
        row_cnt = 0;
        frame_stored = 1'b1;
      end else begin
        row_cnt = row_cnt + 1;
      end
    end else begin
      col_cnt = col_cnt + 1;
    end
    return hit;
  endfunction

  // Free RGB pixels, gray levels placed just around the threshold from the stored
  // value, and unchanged pixels. A pixel whose stored entry
  // was never written is suppressed once a frame is held.
  function automatic pixel_t make_pixel();
    pixel_t      p;
    int unsigned addr;
    int unsigned pick;
    int          reach;
    int          level;
    addr = row_cnt * MAX_W + col_cnt;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      p.red = 8'($urandom);
      p.green = 8'($urandom);
      p.blue = 8'($urandom);
    end else begin
      level = int'(gray_store[addr]);
      if (pick < 80) begin
        reach = int'(threshold_q) + int'($urandom_range(0, 3)) - 1;
        level = $urandom_range(0, 1) ? level + reach : level - reach;
        level = (level < 0) ? 0 : ((level > 255) ? 255 : level);
      end
      p.red = 8'(level);
      p.green = 8'(level);
      p.blue = 8'(level);
    end
    p.suppress = ($urandom_range(0, 9) == 0);
    if (frame_stored && !gray_written[addr]) begin
      p.suppress = 1'b1;
    end
    return p;
  endfunction

  task automatic send_pixel(input pixel_t p, input row_check_t check, input change_t typed);
    change_t chg;
    bit      hit;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.red <= p.red;
    pix_if.green <= p.green;
    pix_if.blue <= p.blue;
    pix_if.suppress <= p.suppress;
    do @(posedge clk); while (!(pix_if.valid && pix_if.ready));
    hit = predict_pixel(p, chg);
    if (check == CHECK_EVENT) begin
      pending_changes = {pending_changes, typed};
    end else if (check == CHECK_MODEL && hit) begin
      pending_changes = {pending_changes, chg};
    end
    n_pixels++;
  endtask

  task automatic hold_until_drained();
    pix_if.valid <= 1'b0;
    do @(posedge clk); while (pending_changes.size() != 0);
  endtask

  // Pixels that cause no item may still sit in the intake queue or the
  // pipeline, so let them retire before touching a register.
  task automatic settle();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode % 4)
      0: begin send_idle_pct = 0; recv_stall_pct = 0; end
      1: begin send_idle_pct = 68; recv_stall_pct = 0; end
      2: begin send_idle_pct = 0; recv_stall_pct = 68; end
      default: begin send_idle_pct = 19; recv_stall_pct = 19; end
    endcase
  endtask

  task automatic write_reg(input cfg_reg_t sel, input int unsigned value);
    logic [PDATA_W-1:0] stored;
    case (sel)
      REG_THRESHOLD: begin stored = value & 32'hFF; threshold_q = stored; end
      REG_WIDTH: begin stored = value & 32'h7FF; width_q = stored; end
      default: begin stored = value & 32'h7FF; height_q = stored; end
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== stored) begin
      $error("register %s readback: expected %0d, got %0d", sel.name(), stored, prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    n_cfg++;
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    out_ready_loop: begin
      evt_if.ready <= 1'b0;
      forever begin
        @(posedge clk);
        evt_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : compare_changes
    change_t want;
    if (rst_n && evt_if.valid && evt_if.ready) begin
      if (pending_changes.size() == 0) begin
        $error("change item with none pending: x=%0d y=%0d polarity=%0d",
               evt_if.event_x, evt_if.event_y, evt_if.polarity);
        errors++;
      end else begin
        want = pending_changes.pop_front();
        if (evt_if.event_x !== want.x) begin
          $error("event_x: expected %0d, got %0d", want.x, evt_if.event_x);
          errors++;
        end
        if (evt_if.event_y !== want.y) begin
          $error("event_y: expected %0d, got %0d", want.y, evt_if.event_y);
          errors++;
        end
        if (evt_if.polarity !== want.pol) begin
          $error("polarity: expected %0d, got %0d", want.pol, evt_if.polarity);
          errors++;
        end
        if (want.pol) n_fall++;
        else n_rise++;
      end
    end
  end

  initial begin
    #4000000;
    $display("event_camera_pixel_change_detector_test: FAIL");
    $finish;
  end

  initial begin
    int unsigned phase;
    int unsigned small_sent;
    int unsigned n;
    int unsigned thr;
    int unsigned wv;
    int unsigned hv;
    bit          big;
    int unsigned guard;
    phase = 0;
    small_sent = 0;
    rst_n <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    pix_if.valid <= 1'b0;
    pix_if.red <= '0;
    pix_if.green <= '0;
    pix_if.blue <= '0;
    pix_if.suppress <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(directed_rows[i].reg_sel, directed_rows[i].value);
      end else begin
        send_pixel(directed_rows[i].pix, directed_rows[i].check, directed_rows[i].want);
      end
    end
    // Zero sizes count as one: a single-pixel frame.
    settle();
    write_reg(REG_WIDTH, 0);
    write_reg(REG_HEIGHT, 0);
    send_pixel(WHITE, CHECK_MODEL, NO_CHG);

    // Full-width rows: the first pass writes the whole row, the second
    // compares the start of the row against what the first pass stored.
    settle();
    set_idling(3);
    write_reg(REG_THRESHOLD, 30);
    write_reg(REG_WIDTH, MAX_W);
    write_reg(REG_HEIGHT, 1);
    for (int i = 0; i < WIDE_ITEMS; i++) begin
      if (i == MAX_W) begin
        hold_until_drained();
        n_drains++;
      end
      send_pixel(make_pixel(), CHECK_MODEL, NO_CHG);
    end

    while (small_sent < SMALL_ITEMS) begin
      phase++;
      settle();
      set_idling(phase);
      case ($urandom_range(0, 7))
        0: thr = 0;
        1: thr = 255;
        default: thr = $urandom_range(0, 60);
      endcase
      big = 1'b0;
      case ($urandom_range(0, 19))
        0: wv = 0;
        1: begin wv = 2047; big = 1'b1; end
        2: begin wv = MAX_W; big = 1'b1; end
        default: wv = $urandom_range(1, 12);
      endcase
      case ($urandom_range(0, 19))
        0: hv = 0;
        1: begin hv = MAX_H; big = 1'b1; end
        2: begin hv = 1500; big = 1'b1; end
        default: hv = $urandom_range(1, 6);
      endcase
      write_reg(REG_THRESHOLD, thr);
      write_reg(REG_WIDTH, wv);
      write_reg(REG_HEIGHT, hv);
      if (wv == 0) wv = 1;
      if (hv == 0) hv = 1;
      // Large frames get only a short burst before the size shrinks again.
      n = big ? $urandom_range(8, 40) : $urandom_range(1, 3 * wv * hv + wv);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 63) == 0) begin
          hold_until_drained();
          n_drains++;
        end
        send_pixel(make_pixel(), CHECK_MODEL, NO_CHG);
        small_sent++;
      end
    end

    pix_if.valid <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (pending_changes.size() != 0 && guard < 20000);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_changes.size() != 0) begin
      $error("%0d change items never arrived", pending_changes.size());
      errors++;
    end
    $display("Sent %0d pixels across %0d register writes and %0d idling phases.",
             n_pixels, n_cfg, phase + 1);
    $display("Checked %0d brightening and %0d darkening items; %0d full drains.",
             n_rise, n_fall, n_drains);
    if (errors == 0) begin
      $display("event_camera_pixel_change_detector_test: PASS");
    end else begin
      $display("event_camera_pixel_change_detector_test: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/ecpcd_pkg.sv
sv/ecpcd_if.sv
sv/ecpcd_ram.sv
sv/ecpcd_front.sv
sv/ecpcd_queue.sv
sv/ecpcd_back.sv
sv/event_camera_pixel_change_detector.sv
tb/sv/event_camera_pixel_change_detector_test.sv
